[sv/lcmt_pkg.sv]
// Shared widths, constants and the node record of the minimum line tree.
package lcmt_pkg;

  localparam int DOMAIN_BITS_DEF = 10;
  localparam int COORD_W = 32;
  localparam int XOFF_W = 10;
  localparam int VAL_W = 63;
  localparam int OPD_W = COORD_W + 1;
  localparam int PROD_W = 2 * OPD_W;
  localparam int SUM_W = PROD_W + 1;

  localparam logic signed [SUM_W-1:0] EMPTY_VAL = 67'sd4611686018427387903;
  localparam logic signed [SUM_W-1:0] LOW_SAT = -67'sd4611686018427387904;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] slope;
    logic signed [COORD_W-1:0] intercept;
  } node_t;

endpackage

[sv/li_chao_min_line_tree.sv]
// Top level of the minimum line tree: sequencer, node memory and shared multiplier.
//
// Input channel (in_valid_i / in_stall_o): mode_i = 0 adds the line
// slope_i * x + intercept_i, mode_i = 1 queries the minimum at min_x + x_offset_i.
// Output channel (out_valid_o / out_stall_i): one min_value_o per query, none per
// add; 2^62-1 when no stored line lies on the path, low values clamp to -2^62.
// Config channel (cfg_valid_i / cfg_ready_o): writes min_x, always ready; write
// it only while the block is idle.
// One item at a time. An add walks each occupied tree level through memory
// read, lo product, mid product and decide, stores into an empty node when the
// walk stops early, and returns to idle. A query walks each occupied level
// through memory read, product and accumulate, checks an empty node when the
// walk stops early, then loads the output and returns to idle. The node
// memory read and the single multiplier set this sequence; in_stall_o is high
// while an item is in work.
// Reset: a clearing pass writes every node entry with in_stall_o high; min_x
// resets to 0.
// A finished result sits in the output register while the next item is taken;
// a query that finishes while that register is still stalled waits for it.
module li_chao_min_line_tree import lcmt_pkg::*; #(
  parameter int DomainBits = DOMAIN_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic signed [COORD_W-1:0] slope_i,
  input  logic signed [COORD_W-1:0] intercept_i,
  input  logic [XOFF_W-1:0]         x_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VAL_W-1:0]   min_value_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic signed [COORD_W-1:0] cfg_min_x_i
);

  localparam int Db = DomainBits;
  localparam int NodeW = Db + 1;
  localparam int TreeSize = 2 ** NodeW;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_CHK   = 9'b000000100,
    ST_MLO   = 9'b000001000,
    ST_MMID  = 9'b000010000,
    ST_DEC   = 9'b000100000,
    ST_QMUL  = 9'b001000000,
    ST_QACC  = 9'b010000000,
    ST_QOUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [NodeW-1:0] clr_q, clr_d;
  logic signed [COORD_W-1:0] min_x_q, min_x_d;
  logic out_valid_q, out_valid_d;

  logic [NodeW-1:0] node_q, node_d;
  logic [Db-1:0] lo_q, lo_d, off_q, off_d;
  logic [NodeW-1:0] span_q, span_d;
  logic mode_q, mode_d;
  logic signed [COORD_W-1:0] na_q, na_d, nd_q, nd_d;
  logic signed [COORD_W-1:0] ca_q, ca_d, cd_q, cd_d;
  logic signed [OPD_W-1:0] da_q, da_d, dd_q, dd_d, xop_q, xop_d;
  logic left_lower_q, left_lower_d;
  logic signed [SUM_W-1:0] best_q, best_d;
  logic signed [VAL_W-1:0] out_q, out_d;

  logic ram_we;
  logic [NodeW-1:0] ram_waddr, ram_raddr;
  node_t ram_wdata, rd_node;
  logic [$bits(node_t)-1:0] ram_rdata;

  logic signed [SUM_W-1:0] sum;
  logic [Db-1:0] mid;
  logic [Db-1:0] off_in;
  logic [Db+XOFF_W-1:0] off_ext;
  logic [NodeW-1:0] child_l, child_r;
  logic mid_lower, last_level, out_free;
  logic signed [OPD_W-1:0] x_lo, x_mid, x_off, min_x_ext;
  logic signed [SUM_W-1:0] best_sat;

  lcmt_ram #(
    .Width($bits(node_t)),
    .Depth(TreeSize)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lcmt_mac u_mac (
    .clk_i(clk_i),
    .a_i  (da_q),
    .b_i  (xop_q),
    .c_i  (dd_q),
    .sum_o(sum)
  );

  assign rd_node = node_t'(ram_rdata);
  assign off_ext = {{Db{1'b0}}, x_offset_i};
  assign off_in = off_ext[Db-1:0];
  assign mid = lo_q + span_q[Db:1];
  assign child_l = {node_q[Db-1:0], 1'b0};
  assign child_r = {node_q[Db-1:0], 1'b1};
  assign mid_lower = sum[SUM_W-1];
  assign last_level = (span_q == NodeW'(1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign min_x_ext = $signed({min_x_q[COORD_W-1], min_x_q});
  assign x_lo = min_x_ext + $signed({{(OPD_W-Db){1'b0}}, lo_q});
  assign x_mid = min_x_ext + $signed({{(OPD_W-Db){1'b0}}, mid});
  assign x_off = min_x_ext + $signed({{(OPD_W-Db){1'b0}}, off_q});
  assign best_sat = (best_q < LOW_SAT) ? LOW_SAT : best_q;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    min_x_d = cfg_valid_i ? cfg_min_x_i : min_x_q;
    out_valid_d = out_valid_q && out_stall_i;
    node_d = node_q;
    lo_d = lo_q;
    off_d = off_q;
    span_d = span_q;
    mode_d = mode_q;
    na_d = na_q;
    nd_d = nd_q;
    ca_d = ca_q;
    cd_d = cd_q;
    da_d = da_q;
    dd_d = dd_q;
    xop_d = xop_q;
    left_lower_d = left_lower_q;
    best_d = best_q;
    out_d = out_q;
    ram_we = 1'b0;
    ram_waddr = node_q;
    ram_wdata = '{valid: 1'b1, slope: na_q, intercept: nd_q};
    ram_raddr = node_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d = clr_q + NodeW'(1);
        if (clr_q == {NodeW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr = NodeW'(1);
        if (in_valid_i) begin
          node_d = NodeW'(1);
          lo_d = '0;
          span_d = {1'b1, {Db{1'b0}}};
          mode_d = mode_i;
          na_d = slope_i;
          nd_d = intercept_i;
          off_d = off_in;
          best_d = EMPTY_VAL;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        ca_d = rd_node.slope;
        cd_d = rd_node.intercept;
        if (!rd_node.valid) begin
          if (mode_q) begin
            state_d = ST_QOUT;
          end else begin
            ram_we = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (mode_q) begin
          da_d = $signed({rd_node.slope[COORD_W-1], rd_node.slope});
          dd_d = $signed({rd_node.intercept[COORD_W-1], rd_node.intercept});
          xop_d = x_off;
          state_d = ST_QMUL;
        end else begin
          da_d = $signed({na_q[COORD_W-1], na_q})
               - $signed({rd_node.slope[COORD_W-1], rd_node.slope});
          dd_d = $signed({nd_q[COORD_W-1], nd_q})
               - $signed({rd_node.intercept[COORD_W-1], rd_node.intercept});
          xop_d = x_lo;
          state_d = ST_MLO;
        end
      end
      ST_MLO: begin
        xop_d = x_mid;
        state_d = ST_MMID;
      end
      ST_MMID: begin
        left_lower_d = sum[SUM_W-1];
        state_d = ST_DEC;
      end
      ST_DEC: begin
        if (mid_lower) begin
          ram_we = 1'b1;
          na_d = ca_q;
          nd_d = cd_q;
        end
        if (last_level) begin
          state_d = ST_IDLE;
        end else begin
          span_d = span_q >> 1;
          if (left_lower_q != mid_lower) begin
            node_d = child_l;
          end else begin
            node_d = child_r;
            lo_d = mid;
          end
          ram_raddr = node_d;
          state_d = ST_CHK;
        end
      end
      ST_QMUL: begin
        state_d = ST_QACC;
      end
      ST_QACC: begin
        if (sum < best_q) begin
          best_d = sum;
        end
        if (last_level) begin
          state_d = ST_QOUT;
        end else begin
          span_d = span_q >> 1;
          if (off_q < mid) begin
            node_d = child_l;
          end else begin
            node_d = child_r;
            lo_d = mid;
          end
          ram_raddr = node_d;
          state_d = ST_CHK;
        end
      end
      ST_QOUT: begin
        if (out_free) begin
          out_d = best_sat[VAL_W-1:0];
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      min_x_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      min_x_q <= min_x_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    lo_q <= lo_d;
    off_q <= off_d;
    span_q <= span_d;
    mode_q <= mode_d;
    na_q <= na_d;
    nd_q <= nd_d;
    ca_q <= ca_d;
    cd_q <= cd_d;
    da_q <= da_d;
    dd_q <= dd_d;
    xop_q <= xop_d;
    left_lower_q <= left_lower_d;
    best_q <= best_d;
    out_q <= out_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign min_value_o = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

[sv/lcmt_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
module lcmt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/lcmt_mac.sv]
// Shared multiply unit: registered product, then add of the line offset.
module lcmt_mac import lcmt_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [OPD_W-1:0] a_i,
  input  logic signed [OPD_W-1:0] b_i,
  input  logic signed [OPD_W-1:0] c_i,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int PExt = SUM_W - PROD_W;
  localparam int CExt = SUM_W - OPD_W;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign sum_o = $signed({{PExt{prod_q[PROD_W-1]}}, prod_q})
               + $signed({{CExt{c_i[OPD_W-1]}}, c_i});

endmodule

[sv/lcmt_chk.sv]
// Port-level checker for the minimum line tree, bound to the top level.
module lcmt_chk import lcmt_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [VAL_W-1:0]   min_value_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(min_value_o))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new transfer taken while busy");

  // no result appears right after an accepted item
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result without tree walk");

  // clearing pass holds off input after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input open during clearing pass");

endmodule

bind li_chao_min_line_tree lcmt_chk u_lcmt_chk (.*);
